/* hdl/csv_line_splitter_char_histogram_top_defines.svh */
// Assertion macros used by the checker module.
`ifndef CSV_LINE_SPLITTER_CHAR_HISTOGRAM_TOP_DEFINES_SVH
`define CSV_LINE_SPLITTER_CHAR_HISTOGRAM_TOP_DEFINES_SVH

// Checked at every clock edge outside reset.
`define CSVH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CSVH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/csvh_pkg.sv */
package csvh_pkg;

  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_COL   = 2'd2;
  localparam logic [1:0] REQ_ENTRY = 2'd3;

  localparam logic [1:0] CFG_SEPARATOR  = 2'd0;
  localparam logic [1:0] CFG_FILTER_ON  = 2'd1;
  localparam logic [1:0] CFG_FILTER_COL = 2'd2;

  localparam logic [7:0] NEWLINE_BYTE    = 8'd10;
  localparam logic [7:0] TERMINATOR_BYTE = 8'd0;
  localparam logic [7:0] SEPARATOR_RESET = 8'd44;
  localparam int         BYTE_VALUES     = 256;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] column_index;
    logic [7:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic        line_done;
    logic        line_blank;
    logic [8:0]  column_total;
    logic [7:0]  byte_column;
    logic [11:0] field_start;
    logic [11:0] field_width;
    logic        answer_valid;
    logic [7:0]  entry_char;
    logic [15:0] entry_count;
    logic [8:0]  distinct_chars;
    logic [12:0] line_length;
    logic        overflow;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic entry_rd;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_type;
  } dp_stat_t;

  function automatic logic is_white(input logic [7:0] b);
    return b inside {8'd32, [8'd9:8'd13]};
  endfunction

endpackage

/* hdl/csvh_ctrl.sv */
module csvh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  csvh_pkg::dp_stat_t stat,
  output csvh_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ENTRY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.req_type == csvh_pkg::REQ_ENTRY) begin
          cmd.entry_rd = 1'b1;
          state_nxt    = S_ENTRY;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ENTRY: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/csvh_dp.sv */
module csvh_dp #(
  parameter int MAX_LINE    = 4096,
  parameter int MAX_COLUMNS = 256,
  parameter int COUNT_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  csvh_pkg::in_item_t  in_item,
  input  csvh_pkg::dp_cmd_t   cmd,
  output csvh_pkg::dp_stat_t  stat,
  output csvh_pkg::out_item_t out_item
);

  localparam int LEN_W = $clog2(MAX_LINE + 1);
  localparam int SEP_W = $clog2(MAX_COLUMNS);

  // Configuration registers.
  logic [7:0] cfg_sep_r;
  logic       cfg_filt_on_r;
  logic [7:0] cfg_filt_col_r;

  // Line state.
  csvh_pkg::in_item_t                        item_r;
  logic [LEN_W-1:0]                          len_r, len_nxt;
  logic [SEP_W-1:0]                          sep_r, sep_nxt;
  logic [8:0]                                seen_tot_r, seen_tot_nxt;
  logic                                      blank_r, blank_nxt;
  logic                                      fin_r, fin_nxt;
  logic                                      ovf_r, ovf_nxt;
  logic [csvh_pkg::BYTE_VALUES-1:0]          cval_r;
  csvh_pkg::out_item_t                       out_r, out_nxt;

  // Memories and their registered read data.
  logic [COUNT_BITS-1:0] cnt_mem [csvh_pkg::BYTE_VALUES];
  logic [7:0]            seen_mem [csvh_pkg::BYTE_VALUES];
  logic [LEN_W-1:0]      off_mem [MAX_COLUMNS];
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [7:0]            seen_rd_r;
  logic [LEN_W-1:0]      off_a_r, off_b_r;

  logic [7:0]            cnt_ra;
  logic                  new_line;

  // Data byte update.
  logic [7:0]            b, cnt_addr;
  logic [COUNT_BITS-1:0] cnt_val;
  logic                  is_data, nl, full, is_sep, col_room, counted;
  logic                  inc_len, open_col, do_count, cnt_sat;
  logic                  cnt_wr, seen_wr;

  // Query answers.
  logic                  col_ok, ent_ok;
  logic [LEN_W-1:0]      f_start, f_end, f_width;

  assign stat.req_type = item_r.req_type;
  assign out_item      = out_r;

  assign cnt_ra = cmd.entry_rd ? seen_rd_r :
                  (in_item.data_byte == csvh_pkg::NEWLINE_BYTE) ?
                  csvh_pkg::TERMINATOR_BYTE : in_item.data_byte;

  assign new_line = cmd.accept &&
                    ((in_item.req_type == csvh_pkg::REQ_DATA && fin_r) ||
                     in_item.req_type == csvh_pkg::REQ_END);

  always_comb begin
    b        = item_r.data_byte;
    is_data  = (item_r.req_type == csvh_pkg::REQ_DATA);
    nl       = (b == csvh_pkg::NEWLINE_BYTE);
    cnt_addr = nl ? csvh_pkg::TERMINATOR_BYTE : b;
    cnt_val  = cval_r[cnt_addr] ? cnt_rd_r : '0;
    full     = (len_r >= LEN_W'(MAX_LINE - 1));
    is_sep   = (b == cfg_sep_r);
    col_room = (sep_r < SEP_W'(MAX_COLUMNS - 1));
    counted  = !cfg_filt_on_r || (32'(sep_r) == 32'(cfg_filt_col_r));
    inc_len  = 1'b0;
    open_col = 1'b0;
    do_count = 1'b0;
    len_nxt      = len_r;
    sep_nxt      = sep_r;
    blank_nxt    = blank_r;
    fin_nxt      = fin_r;
    ovf_nxt      = ovf_r;
    seen_tot_nxt = seen_tot_r;
    if (is_data) begin
      if (nl) begin
        inc_len  = 1'b1;
        do_count = !cfg_filt_on_r;
        fin_nxt  = 1'b1;
      end else if (full) begin
        ovf_nxt = 1'b1;
      end else if (is_sep && col_room) begin
        inc_len  = 1'b1;
        open_col = 1'b1;
        do_count = !cfg_filt_on_r;
      end else begin
        // Text, or a separator past the column limit, which counts as text.
        inc_len  = 1'b1;
        do_count = counted;
        if (is_sep) begin
          ovf_nxt = 1'b1;
        end
        if (!csvh_pkg::is_white(b)) begin
          blank_nxt = 1'b0;
        end
      end
    end
    cnt_sat = (cnt_val == {COUNT_BITS{1'b1}});
    cnt_wr  = do_count && !cnt_sat;
    seen_wr = do_count && (cnt_val == '0) && (seen_tot_r < 9'(csvh_pkg::BYTE_VALUES));
    if (do_count && cnt_sat) begin
      ovf_nxt = 1'b1;
    end
    if (seen_wr) begin
      seen_tot_nxt = seen_tot_r + 9'd1;
    end
    if (inc_len) begin
      len_nxt = len_r + LEN_W'(1);
    end
    if (open_col) begin
      sep_nxt = sep_r + SEP_W'(1);
    end

    col_ok  = fin_r && !blank_r && (32'(item_r.column_index) <= 32'(sep_r));
    ent_ok  = ({1'b0, item_r.entry_index} < seen_tot_r);
    f_start = (item_r.column_index == 8'd0) ? '0 : off_a_r;
    f_end   = (32'(item_r.column_index) == 32'(sep_r)) ? len_r : off_b_r;
    f_width = (f_end > f_start) ? f_end - f_start - LEN_W'(1) : '0;

    out_nxt                = '0;
    out_nxt.line_done      = is_data && nl;
    out_nxt.line_blank     = blank_nxt;
    out_nxt.column_total   = blank_nxt ? 9'd0 : 9'({1'b0, sep_nxt} + (SEP_W + 1)'(1));
    out_nxt.byte_column    = is_data ? 8'(sep_r) : 8'd0;
    out_nxt.distinct_chars = seen_tot_nxt;
    out_nxt.line_length    = 13'(len_nxt);
    out_nxt.overflow       = ovf_nxt;
    if (item_r.req_type == csvh_pkg::REQ_COL && col_ok) begin
      out_nxt.answer_valid = 1'b1;
      out_nxt.field_start  = 12'(f_start);
      out_nxt.field_width  = 12'(f_width);
    end
    if (item_r.req_type == csvh_pkg::REQ_ENTRY && ent_ok) begin
      out_nxt.answer_valid = 1'b1;
      out_nxt.entry_char   = seen_rd_r;
      out_nxt.entry_count  = 16'(cnt_rd_r);
    end
  end

  // Configuration and line state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sep_r      <= csvh_pkg::SEPARATOR_RESET;
      cfg_filt_on_r  <= 1'b0;
      cfg_filt_col_r <= 8'd0;
      len_r          <= '0;
      sep_r          <= '0;
      seen_tot_r     <= '0;
      blank_r        <= 1'b1;
      fin_r          <= 1'b1;
      ovf_r          <= 1'b0;
      cval_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          csvh_pkg::CFG_SEPARATOR:  cfg_sep_r      <= cfg_wdata;
          csvh_pkg::CFG_FILTER_ON:  cfg_filt_on_r  <= cfg_wdata[0];
          csvh_pkg::CFG_FILTER_COL: cfg_filt_col_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (new_line) begin
        len_r      <= '0;
        sep_r      <= '0;
        seen_tot_r <= '0;
        blank_r    <= 1'b1;
        ovf_r      <= 1'b0;
        cval_r     <= '0;
        fin_r      <= (in_item.req_type == csvh_pkg::REQ_END);
      end else if (cmd.commit && is_data) begin
        len_r      <= len_nxt;
        sep_r      <= sep_nxt;
        seen_tot_r <= seen_tot_nxt;
        blank_r    <= blank_nxt;
        fin_r      <= fin_nxt;
        ovf_r      <= ovf_nxt;
        if (cnt_wr) begin
          cval_r[cnt_addr] <= 1'b1;
        end
      end
    end
  end

  // Held item and result register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_item;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  // Histogram counts.
  always_ff @(posedge clk) begin
    if (cmd.commit && is_data && cnt_wr) begin
      cnt_mem[cnt_addr] <= cnt_val + COUNT_BITS'(1);
    end
    if (cmd.accept || cmd.entry_rd) begin
      cnt_rd_r <= cnt_mem[cnt_ra];
    end
  end

  // Byte values in order of first appearance.
  always_ff @(posedge clk) begin
    if (cmd.commit && is_data && seen_wr) begin
      seen_mem[seen_tot_r[7:0]] <= cnt_addr;
    end
    if (cmd.accept) begin
      seen_rd_r <= seen_mem[in_item.entry_index];
    end
  end

  // Column start offsets, two read ports for a column's two ends.
  always_ff @(posedge clk) begin
    if (cmd.commit && is_data && open_col) begin
      off_mem[sep_r] <= len_nxt;
    end
    if (cmd.accept) begin
      off_a_r <= off_mem[SEP_W'(in_item.column_index - 8'd1)];
      off_b_r <= off_mem[SEP_W'(in_item.column_index)];
    end
  end

endmodule

/* hdl/csv_line_splitter_char_histogram_top.sv */
// Each item is taken in, then its update is applied and its result loaded into the output
// register; an entry read adds a state between the two and chains two dependent reads of the
// seen list and the count memory. No new item is taken in until the last one's result is loaded.
// Reset (synchronous, rst_n low) clears the line state, the configuration and the
// histogram valid bits at once; no clearing pass follows reset.
module csv_line_splitter_char_histogram_top #(
  parameter int MAX_LINE    = 4096,
  parameter int MAX_COLUMNS = 256,
  parameter int COUNT_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  csvh_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output csvh_pkg::out_item_t out_item
);

  // The controller sequences each item: it takes the item in and starts the memory reads, then
  // applies the update and loads the result register once the output register is free. An entry
  // read adds a state between the two to look up the count of the byte value it found.
  csvh_pkg::dp_cmd_t  cmd;
  csvh_pkg::dp_stat_t stat;

  csvh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the line state, the histogram with its per-value valid bits,
  // the seen list and the column offsets. A result that waits in the output register
  // does not keep the next item from being transferred in.
  csvh_dp #(
    .MAX_LINE    (MAX_LINE),
    .MAX_COLUMNS (MAX_COLUMNS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

endmodule

/* hdl/csvh_chk.sv */
`include "csv_line_splitter_char_histogram_top_defines.svh"

module csvh_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input csvh_pkg::out_item_t out_item
);

  `CSVH_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `CSVH_ASSERT(a_busy_after_transfer, in_valid && !in_stall |=> in_stall, "second item taken too early")
  `CSVH_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result shown after reset")
  `CSVH_ASSERT(a_done_length, out_valid && out_item.line_done |-> out_item.line_length != 13'd0, "finished line with no length")

endmodule

bind csv_line_splitter_char_histogram_top csvh_chk u_chk (.*);
